// ===== sv/efd_pkg.sv =====
// Shared constants and types for the escaped frame decoder.
`timescale 1ns / 1ps

package efd_pkg;

  localparam logic [7:0] BYTE_START = 8'h80;
  localparam logic [7:0] BYTE_END   = 8'h81;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] ESC_START  = 8'hE7;
  localparam logic [7:0] ESC_END    = 8'hE8;
  localparam logic [7:0] ESC_ESC    = 8'h00;
  localparam logic [7:0] CHECK_MASK = 8'h7F;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_GOOD   = 3'd1;
  localparam logic [2:0] KIND_BADSUM = 3'd2;
  localparam logic [2:0] KIND_BADESC = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;
  localparam logic [2:0] KIND_ABORT  = 3'd5;

  typedef struct packed {
    logic       in_frame;
    logic       esc_pending;
    logic       held_valid;
    logic [7:0] held_byte;
    logic [7:0] running_xor;
  } efd_state_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [2:0] kind;
  } efd_result_t;

endpackage

// ===== sv/efd_decode.sv =====
// Per-byte deframing step: next frame state and the word it releases, if any.
`timescale 1ns / 1ps

module efd_decode (
  input  efd_pkg::efd_state_t  state_i,
  input  logic [7:0]           byte_i,
  output efd_pkg::efd_state_t  state_o,
  output efd_pkg::efd_result_t res_o
);
  import efd_pkg::*;

  efd_state_t cleared;
  logic [7:0] unesc;
  logic       unesc_ok;
  logic       push;
  logic [7:0] push_byte;

  always_comb begin
    cleared = '0;
    unesc_ok = 1'b1;
    case (byte_i)
      ESC_START: unesc = BYTE_START;
      ESC_END:   unesc = BYTE_END;
      ESC_ESC:   unesc = BYTE_ESC;
      default: begin
        unesc    = 8'h00;
        unesc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_o   = state_i;
    res_o     = '0;
    push      = 1'b0;
    push_byte = byte_i;

    if (!state_i.in_frame) begin
      if (byte_i == BYTE_START) begin
        state_o          = cleared;
        state_o.in_frame = 1'b1;
      end
    end else if (byte_i == BYTE_START) begin
      // A fresh start inside a frame aborts it and opens the next one.
      state_o          = cleared;
      state_o.in_frame = 1'b1;
      res_o.vld        = 1'b1;
      res_o.kind       = KIND_ABORT;
    end else if (state_i.esc_pending) begin
      if (unesc_ok) begin
        push      = 1'b1;
        push_byte = unesc;
      end else begin
        state_o    = cleared;
        res_o.vld  = 1'b1;
        res_o.kind = KIND_BADESC;
      end
    end else if (byte_i == BYTE_END) begin
      state_o   = cleared;
      res_o.vld = 1'b1;
      if (!state_i.held_valid) begin
        res_o.kind = KIND_EMPTY;
      end else if (state_i.held_byte == (state_i.running_xor & CHECK_MASK)) begin
        res_o.kind = KIND_GOOD;
      end else begin
        res_o.kind = KIND_BADSUM;
      end
    end else if (byte_i == BYTE_ESC) begin
      state_o.esc_pending = 1'b1;
    end else begin
      push = 1'b1;
    end

    // The held byte is released as data once a newer decoded byte replaces it.
    if (push) begin
      state_o.esc_pending = 1'b0;
      state_o.held_valid  = 1'b1;
      state_o.held_byte   = push_byte;
      if (state_i.held_valid) begin
        state_o.running_xor = state_i.running_xor ^ state_i.held_byte;
        res_o.vld           = 1'b1;
        res_o.data          = state_i.held_byte;
        res_o.kind          = KIND_DATA;
      end
    end
  end

endmodule

// ===== sv/escaped_frame_decoder_xor_check.sv =====
// Top level of the escaped frame decoder with XOR check byte.
//
// Input channel: one raw line byte per word on in_byte, taken when in_valid
// is high and in_stall is low. Result channel: out_byte and out_kind, taken
// when out_valid is high and out_stall is low. Each input word yields at most
// one result word: a decoded data byte (kind 0) or a frame status (kinds 1 to
// 5, with out_byte zero). The final decoded byte of a frame is the check byte
// and never appears as data.
// An accepted word is loaded into the input register; its decode result is then
// written into the result register, which drives out_valid, once that register
// is free. One word is accepted every cycle while the result side keeps taking
// words.
// When out_stall holds a result, the input register is held too and in_stall
// rises once it is full; the result payload stays stable while stalled.
// Synchronous reset (rst_n low) empties both registers, leaves the decoder
// outside any frame, and holds in_stall high for its duration.
`timescale 1ns / 1ps

module escaped_frame_decoder_xor_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind
);
  import efd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  efd_state_t  state_r, state_nxt, step_state;
  efd_result_t step_res;
  logic        out_vld_r, out_vld_nxt;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_kind_r;
  logic        advance;
  logic        in_take;

  efd_decode u_decode (
    .state_i (state_r),
    .byte_i  (in_byte_r),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // The input register moves on whenever the result register is free.
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = !rst_n || (in_vld_r && !advance);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = in_vld_r && step_res.vld;
      in_vld_nxt  = 1'b0;
      if (in_vld_r) begin
        state_nxt = step_state;
      end
    end
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      state_r   <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
    end
    if (advance) begin
      out_byte_r <= step_res.data;
      out_kind_r <= step_res.kind;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;

endmodule

// ===== sv/efd_checker.sv =====
// Port-level checks for the escaped frame decoder, bound to its top level.
`timescale 1ns / 1ps

module efd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [2:0] out_kind
);
  import efd_pkg::*;

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("result word changed while stalled");

  // Status words carry a zero byte.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'h00)
    else $error("status word with non-zero byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_GOOD ||
                   out_kind == KIND_BADSUM || out_kind == KIND_BADESC ||
                   out_kind == KIND_EMPTY || out_kind == KIND_ABORT))
    else $error("result kind out of range");

  // A result can only appear after an input word was taken.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without a matching input word");

  // An accepted byte must be fully known.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_byte))
    else $error("unknown byte accepted");

endmodule

bind escaped_frame_decoder_xor_check efd_checker u_efd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_kind  (out_kind)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the escaped frame decoder with XOR check byte.
`timescale 1ns / 1ps

module tb;
  import efd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
  } result_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] out_kind;

  logic [7:0]   line_bytes[$];
  result_word_t expected_words[$];
  efd_state_t   dec_st = '0;
  int           mismatches = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           cycle_cnt = 0;
  logic         quiet = 1'b0;
  logic         long_hold = 1'b0;

  escaped_frame_decoder_xor_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic post_result(input logic [7:0] data, input logic [2:0] kind);
    result_word_t w;
    w.data = data;
    w.kind = kind;
    expected_words.push_back(w);
  endtask

  // The newest decoded byte may be the check byte, so the previous one is
  // released as data only now.
  task automatic hold_decoded(input logic [7:0] d);
    if (dec_st.held_valid) begin
      post_result(dec_st.held_byte, KIND_DATA);
      dec_st.running_xor = dec_st.running_xor ^ dec_st.held_byte;
    end
    dec_st.held_byte  = d;
    dec_st.held_valid = 1'b1;
  endtask

  task automatic decode_line_byte(input logic [7:0] b);
    if (!dec_st.in_frame) begin
      if (b == BYTE_START) begin
        dec_st = '0;
        dec_st.in_frame = 1'b1;
      end
      return;
    end
    if (b == BYTE_START) begin
      dec_st = '0;
      dec_st.in_frame = 1'b1;
      post_result(8'h00, KIND_ABORT);
      return;
    end
    if (dec_st.esc_pending) begin
      dec_st.esc_pending = 1'b0;
      case (b)
        ESC_START: hold_decoded(BYTE_START);
        ESC_END:   hold_decoded(BYTE_END);
        ESC_ESC:   hold_decoded(BYTE_ESC);
        default: begin
          dec_st = '0;
          post_result(8'h00, KIND_BADESC);
        end
      endcase
      return;
    end
    if (b == BYTE_END) begin
      if (!dec_st.held_valid)
        post_result(8'h00, KIND_EMPTY);
      else if (dec_st.held_byte == (dec_st.running_xor & CHECK_MASK))
        post_result(8'h00, KIND_GOOD);
      else
        post_result(8'h00, KIND_BADSUM);
      dec_st = '0;
      return;
    end
    if (b == BYTE_ESC)
      dec_st.esc_pending = 1'b1;
    else
      hold_decoded(b);
  endtask

  // ---------------------------------------------------------------- stimulus

  // Mostly no idling, some short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] pick_payload();
    if ($urandom_range(0, 1) == 0)
      return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return BYTE_START;
      1: return BYTE_END;
      2: return BYTE_ESC;
      3: return ESC_START;
      4: return ESC_END;
      5: return ESC_ESC;
      6: return CHECK_MASK;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic push_stuffed(input logic [7:0] d);
    case (d)
      BYTE_START: begin line_bytes.push_back(BYTE_ESC); line_bytes.push_back(ESC_START); end
      BYTE_END:   begin line_bytes.push_back(BYTE_ESC); line_bytes.push_back(ESC_END);   end
      BYTE_ESC:   begin line_bytes.push_back(BYTE_ESC); line_bytes.push_back(ESC_ESC);   end
      default:    line_bytes.push_back(d);
    endcase
  endtask

  // Inserts something that breaks the frame: a raw start, a bad escape
  // or an escape followed by the closing byte.
  task automatic push_breakage();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: line_bytes.push_back(BYTE_START);
      1: begin
        do
          b = 8'($urandom_range(0, 255));
        while (b == ESC_START || b == ESC_END || b == ESC_ESC || b == BYTE_START);
        line_bytes.push_back(BYTE_ESC);
        line_bytes.push_back(b);
      end
      default: begin
        line_bytes.push_back(BYTE_ESC);
        line_bytes.push_back(BYTE_END);
      end
    endcase
  endtask

  task automatic push_frame();
    int         n;
    int         break_at;
    logic [7:0] x;
    logic [7:0] d;
    x = 8'h00;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
    break_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n) : -1;
    line_bytes.push_back(BYTE_START);
    if ($urandom_range(0, 19) == 0) begin
      // Empty frame: nothing at all between start and close.
      line_bytes.push_back(BYTE_END);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (i == break_at)
        push_breakage();
      d = pick_payload();
      x = x ^ d;
      push_stuffed(d);
    end
    if (break_at == n)
      push_breakage();
    push_stuffed(($urandom_range(0, 3) != 0) ? (x & CHECK_MASK) : pick_payload());
    line_bytes.push_back(BYTE_END);
  endtask

  // ------------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        decode_line_byte(in_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !quiet) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (line_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= line_bytes.pop_front();
          gap_left <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stretches with no idling on either side, and two long receiver hold-offs
  // during which the sender keeps offering words so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_cnt <= 0;
      quiet     <= 1'b0;
      long_hold <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      quiet     <= (cycle_cnt % 600) < 120;
      long_hold <= (cycle_cnt >= 300 && cycle_cnt < 380) ||
                   (cycle_cnt >= 1500 && cycle_cnt < 1600);
    end
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    result_word_t want;
    int           pick;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with none expected: byte %02h kind %0d",
                     $realtime, out_byte, out_kind);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.data || out_kind !== want.kind) begin
            if (mismatches < 10)
              $display("%0t: expected byte %02h kind %0d, got byte %02h kind %0d",
                       $realtime, want.data, want.kind, out_byte, out_kind);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        pick = idle_len();
        out_stall  <= (pick > 0);
        stall_left <= (pick > 0) ? pick - 1 : 0;
      end
    end
  end

  // --------------------------------------------------------------------- main

  initial begin
    int waited;
    // Directed opening: ignored bytes, empty frame, one-byte frames, every
    // escape, escape before close, escape before start, raw start, bad escape.
    line_bytes = '{8'h00, 8'hFF,
                   BYTE_START, BYTE_END,
                   BYTE_START, 8'h00, BYTE_END,
                   BYTE_START, 8'hFF, BYTE_END,
                   BYTE_START, BYTE_ESC, ESC_START, BYTE_ESC, ESC_END, BYTE_ESC, ESC_ESC,
                   8'h1A, BYTE_END,
                   BYTE_START, BYTE_ESC, BYTE_END,
                   BYTE_START, BYTE_ESC, BYTE_START,
                   8'h55, BYTE_START,
                   BYTE_ESC, 8'h55};
    while (line_bytes.size() < 1280) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3))
          line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        push_frame();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (line_bytes.size() != 0 || in_valid)
      @(posedge clk);
    waited = 0;
    while (expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $display("%0d expected result words never arrived", expected_words.size());
      mismatches = mismatches + 1;
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/efd_pkg.sv
sv/efd_decode.sv
sv/escaped_frame_decoder_xor_check.sv
sv/efd_checker.sv
sim/tb.sv
